[rtl/owo_pkg.sv]
package owo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_DEPTH   = 24;
    localparam int STEP_W       = $clog2(ATAN_DEPTH);

    localparam int COUNT_W      = 16;
    localparam int MM_W         = 16;
    localparam int TURN_W       = 24;
    localparam int ANG_W        = 32;
    localparam int POS_W        = 40;
    localparam int WHEELS       = 4;

    localparam int MUL_A_W      = 19;
    localparam int MUL_B_W      = 31;
    localparam int MUL_P_W      = MUL_A_W + MUL_B_W;

    localparam int WHEEL_W      = COUNT_W + MM_W + 1;
    localparam int LOCAL_W      = WHEEL_W;
    localparam int VEC_W        = 36;

    localparam int GAIN_W       = 30;
    localparam int GAIN_SHIFT   = 30;
    localparam int GAIN_SPLIT   = MUL_A_W - 1;
    localparam int GAIN_ACC_W   = 64;
    localparam int GAIN_OUT_W   = GAIN_ACC_W - GAIN_SHIFT;

    localparam logic [GAIN_W-1:0]     GAIN_Q30   = 30'd652032874;
    localparam logic [GAIN_ACC_W-1:0] GAIN_ROUND = 64'd1 << (GAIN_SHIFT - 1);
    localparam logic [ANG_W-1:0]      EIGHTH     = 32'h2000_0000;

    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 24;

    localparam logic [MM_W-1:0]   MM_RESET   = 16'd10053;
    localparam logic [TURN_W-1:0] TURN_RESET = 24'd119156;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MM_PER_COUNT   = 8'd0,
        REG_TURN_PER_COUNT = 8'd1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] count_a;
        logic signed [COUNT_W-1:0] count_b;
        logic signed [COUNT_W-1:0] count_c;
        logic signed [COUNT_W-1:0] count_d;
    } enc_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic        [ANG_W-1:0] heading;
    } pose_word_t;

    function automatic logic signed [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[rtl/owo_mult.sv]
module owo_mult (
    input  logic                                 clk,
    input  logic signed [owo_pkg::MUL_A_W-1:0]   a,
    input  logic signed [owo_pkg::MUL_B_W-1:0]   b,
    output logic signed [owo_pkg::MUL_P_W-1:0]   p
);
    import owo_pkg::*;

    logic signed [MUL_P_W-1:0] p_next;
    logic signed [MUL_P_W-1:0] p_reg;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[rtl/owo_cordic.sv]
module owo_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [owo_pkg::VEC_W-1:0]   x0,
    input  logic signed [owo_pkg::VEC_W-1:0]   y0,
    input  logic signed [owo_pkg::ANG_W-1:0]   z0,
    output logic                               done,
    output logic signed [owo_pkg::VEC_W-1:0]   x,
    output logic signed [owo_pkg::VEC_W-1:0]   y
);
    import owo_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                  state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    done_reg;
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;

    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [VEC_W-1:0] x_next;
    logic signed [VEC_W-1:0] y_next;
    logic signed [ANG_W-1:0] z_next;
    logic signed [ANG_W-1:0] angle;
    logic                    last_step;

    always_comb
    begin
        xs        = x_reg >>> step_reg;
        ys        = y_reg >>> step_reg;
        angle     = atan_turn(step_reg);
        last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
        if (!z_reg[ANG_W-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - angle;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        x_reg     <= x0;
                        y_reg     <= y0;
                        z_reg     <= z0;
                        step_reg  <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;

endmodule

[rtl/omni_wheel_odometry.sv]
// Channel  Dir  Handshake            Payload
// enc      in   enc_valid/enc_ready  enc_word  (four raw encoder counts)
// pose     out  pose_valid/pose_ready pose_word (pos_x, pos_y, heading)
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each word is accepted only from idle and is finished before the next acceptance:
// nine products through the shared multiplier, plus one rotation step per cycle
// in the CORDIC unit.
// Reset clears counts, position and heading and loads the register defaults.
// A finished pose waits in the output register; a stalled pose_ready holds the
// sequencer at its last step until the pose register is free. cfg_ready stays high.
module omni_wheel_odometry (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  enc_valid,
    output logic                                  enc_ready,
    input  owo_pkg::enc_word_t                    enc_word,
    output logic                                  pose_valid,
    input  logic                                  pose_ready,
    output owo_pkg::pose_word_t                   pose_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [owo_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [owo_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import owo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_ROT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_W0,
        OP_W1,
        OP_W2,
        OP_W3,
        OP_TURN,
        OP_XL,
        OP_XH,
        OP_YL,
        OP_YH
    } op_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    state_t                     state_reg;
    op_t                        op_reg;
    logic                       phase_reg;
    logic [MM_W-1:0]            mm_reg;
    logic [TURN_W-1:0]          turn_reg;
    logic [COUNT_W-1:0]         last_reg [WHEELS];
    logic [ANG_W-1:0]           head_reg;
    logic signed [POS_W-1:0]    acc_x_reg;
    logic signed [POS_W-1:0]    acc_y_reg;
    logic                       pose_valid_reg;
    pose_word_t                 pose_word_reg;

    logic signed [COUNT_W-1:0]    diff_reg  [WHEELS];
    logic signed [MUL_A_W-1:0]    sum_reg;
    logic signed [WHEEL_W-1:0]    wheel_reg [WHEELS];
    logic signed [GAIN_ACC_W-1:0] gacc_reg;
    logic signed [GAIN_OUT_W-1:0] gx_reg;

    logic [COUNT_W-1:0]           now_cnt   [WHEELS];
    logic signed [COUNT_W-1:0]    diff_next [WHEELS];
    logic signed [MUL_A_W-1:0]    sum_next;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [MUL_P_W-1:0]    prod;
    logic signed [GAIN_ACC_W-1:0] prod_ext;
    logic signed [GAIN_OUT_W-1:0] gy;
    logic signed [POS_W-1:0]      acc_x_next;
    logic signed [POS_W-1:0]      acc_y_next;

    logic signed [LOCAL_W:0]      dx_wide;
    logic signed [LOCAL_W:0]      dy_wide;
    logic signed [LOCAL_W-1:0]    lx;
    logic signed [LOCAL_W-1:0]    ly;
    logic [ANG_W-1:0]             qsum;
    quad_t                        quad;
    logic [ANG_W-1:0]             res;
    logic signed [VEC_W-1:0]      x0;
    logic signed [VEC_W-1:0]      y0;
    logic                         rot_start;
    logic                         rot_done;
    logic signed [VEC_W-1:0]      cx;
    logic signed [VEC_W-1:0]      cy;

    logic                         enc_take;
    logic                         pose_free;

    assign enc_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign enc_take  = enc_valid && enc_ready;
    assign pose_free = !pose_valid_reg || pose_ready;
    assign rot_start = (state_reg == S_PREP);

    assign now_cnt[0] = enc_word.count_a;
    assign now_cnt[1] = enc_word.count_b;
    assign now_cnt[2] = enc_word.count_c;
    assign now_cnt[3] = enc_word.count_d;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < WHEELS; k++)
        begin
            diff_next[k] = now_cnt[k] - last_reg[k];
            sum_next     = sum_next + MUL_A_W'(diff_next[k]);
        end
    end

    always_comb
    begin
        mul_b = MUL_B_W'({1'b0, GAIN_Q30});
        case (op_reg)
            OP_W0:
            begin
                mul_a = MUL_A_W'(diff_reg[0]);
                mul_b = MUL_B_W'({1'b0, mm_reg});
            end
            OP_W1:
            begin
                mul_a = MUL_A_W'(diff_reg[1]);
                mul_b = MUL_B_W'({1'b0, mm_reg});
            end
            OP_W2:
            begin
                mul_a = MUL_A_W'(diff_reg[2]);
                mul_b = MUL_B_W'({1'b0, mm_reg});
            end
            OP_W3:
            begin
                mul_a = MUL_A_W'(diff_reg[3]);
                mul_b = MUL_B_W'({1'b0, mm_reg});
            end
            OP_TURN:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'({1'b0, turn_reg});
            end
            OP_XL:   mul_a = {1'b0, cx[GAIN_SPLIT-1:0]};
            OP_XH:   mul_a = {cx[VEC_W-1], cx[VEC_W-1:GAIN_SPLIT]};
            OP_YL:   mul_a = {1'b0, cy[GAIN_SPLIT-1:0]};
            OP_YH:   mul_a = {cy[VEC_W-1], cy[VEC_W-1:GAIN_SPLIT]};
            default: mul_a = '0;
        endcase
    end

    owo_mult u_mult (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign prod_ext = GAIN_ACC_W'(prod);

    always_comb
    begin
        dx_wide = (LOCAL_W + 1)'(wheel_reg[1]) - (LOCAL_W + 1)'(wheel_reg[3]);
        dy_wide = (LOCAL_W + 1)'(wheel_reg[2]) - (LOCAL_W + 1)'(wheel_reg[0]);
        lx      = dx_wide[LOCAL_W:1];
        ly      = dy_wide[LOCAL_W:1];
        qsum    = head_reg + EIGHTH;
        quad    = quad_t'(qsum[ANG_W-1:ANG_W-2]);
        res     = head_reg - {qsum[ANG_W-1:ANG_W-2], {(ANG_W-2){1'b0}}};
        case (quad)
            QUAD_0:
            begin
                x0 = VEC_W'(lx);
                y0 = VEC_W'(ly);
            end
            QUAD_90:
            begin
                x0 = -VEC_W'(ly);
                y0 = VEC_W'(lx);
            end
            QUAD_180:
            begin
                x0 = -VEC_W'(lx);
                y0 = -VEC_W'(ly);
            end
            QUAD_270:
            begin
                x0 = VEC_W'(ly);
                y0 = -VEC_W'(lx);
            end
            default:
            begin
                x0 = VEC_W'(lx);
                y0 = VEC_W'(ly);
            end
        endcase
    end

    owo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .x0    (x0),
        .y0    (y0),
        .z0    (res),
        .done  (rot_done),
        .x     (cx),
        .y     (cy)
    );

    assign gy         = gacc_reg[GAIN_ACC_W-1:GAIN_SHIFT];
    assign acc_x_next = acc_x_reg + POS_W'(gx_reg);
    assign acc_y_next = acc_y_reg + POS_W'(gy);

    always_ff @(posedge clk)
    begin
        if (enc_take)
        begin
            for (int k = 0; k < WHEELS; k++)
            begin
                diff_reg[k] <= diff_next[k];
            end
            sum_reg <= sum_next;
        end
        if (state_reg == S_MUL && phase_reg)
        begin
            case (op_reg)
                OP_W0: wheel_reg[0] <= prod[WHEEL_W-1:0];
                OP_W1: wheel_reg[1] <= prod[WHEEL_W-1:0];
                OP_W2: wheel_reg[2] <= prod[WHEEL_W-1:0];
                OP_W3: wheel_reg[3] <= prod[WHEEL_W-1:0];
                OP_XL: gacc_reg <= GAIN_ROUND + prod_ext;
                OP_XH: gacc_reg <= gacc_reg + (prod_ext <<< GAIN_SPLIT);
                OP_YL:
                begin
                    gx_reg   <= gacc_reg[GAIN_ACC_W-1:GAIN_SHIFT];
                    gacc_reg <= GAIN_ROUND + prod_ext;
                end
                OP_YH: gacc_reg <= gacc_reg + (prod_ext <<< GAIN_SPLIT);
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_W0;
            phase_reg      <= 1'b0;
            mm_reg         <= MM_RESET;
            turn_reg       <= TURN_RESET;
            for (int k = 0; k < WHEELS; k++)
            begin
                last_reg[k] <= '0;
            end
            head_reg       <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            pose_valid_reg <= 1'b0;
            pose_word_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MM_PER_COUNT)
                begin
                    mm_reg <= cfg_data[MM_W-1:0];
                end
                else if (cfg_index == REG_TURN_PER_COUNT)
                begin
                    turn_reg <= cfg_data[TURN_W-1:0];
                end
            end

            if (pose_valid_reg && pose_ready && state_reg != S_FINISH)
            begin
                pose_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (enc_take)
                    begin
                        for (int k = 0; k < WHEELS; k++)
                        begin
                            last_reg[k] <= now_cnt[k];
                        end
                        op_reg    <= OP_W0;
                        phase_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        case (op_reg)
                            OP_TURN:
                            begin
                                head_reg  <= head_reg - prod[ANG_W-1:0];
                                state_reg <= S_PREP;
                            end
                            OP_YH:
                            begin
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                op_reg <= op_t'(op_reg + 1'b1);
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (rot_done)
                    begin
                        op_reg    <= OP_XL;
                        phase_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_FINISH:
                begin
                    if (pose_free)
                    begin
                        acc_x_reg             <= acc_x_next;
                        acc_y_reg             <= acc_y_next;
                        pose_word_reg.pos_x   <= acc_x_next;
                        pose_word_reg.pos_y   <= acc_y_next;
                        pose_word_reg.heading <= head_reg;
                        pose_valid_reg        <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose_word  = pose_word_reg;

endmodule

[rtl/omni_wheel_odometry_chk.sv]
module omni_wheel_odometry_chk (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  enc_valid,
    input  logic                                  enc_ready,
    input  logic                                  pose_valid,
    input  logic                                  pose_ready,
    input  owo_pkg::pose_word_t                   pose_word,
    input  logic                                  cfg_ready
);

    // hold a stalled pose word
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> pose_valid && $stable(pose_word))
        else $error("pose word dropped or changed while stalled");

    // drop ready once a word is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        enc_valid && enc_ready |=> !enc_ready)
        else $error("enc_ready high right after an accepted word");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid) |-> !$past(enc_ready))
        else $error("pose appeared while the block was idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        !pose_valid |=> pose_valid || $stable(pose_word))
        else $error("pose word changed without a new result");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("cfg_ready dropped");

endmodule

bind omni_wheel_odometry omni_wheel_odometry_chk u_chk (.*);
